>>> design/plrrp_pkg.sv
// Shared constants and word types for the priority level round-robin picker.
package plrrp_pkg;

   // Table geometry
   localparam int ENTRIES = 64;
   localparam int LEVELS  = 6;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int OFF_W   = IDX_W + 1;
   localparam int SLOT_W  = $clog2(LEVELS);
   // Wide enough for level numbers 1..LEVELS at the largest LEVELS
   localparam int LV_W    = 4;
   // The entry index field always spans the whole table at this size
   localparam bit IDX_FITS = ENTRIES >= 64;

   // Level rules for a write
   localparam logic [2:0] LEVEL_MIN      = 3'd1;
   localparam logic [2:0] LEVEL_MAX      = 3'd6;
   localparam logic [2:0] FALLBACK_LEVEL = 3'd5;

   // Action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_PICK  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] entry_index;
      logic       runnable;
      logic [2:0] priority_req;
      logic [1:0] entry_queue;
      logic       order;
      logic [1:0] queue_filter;
   } req_word_type;

   typedef struct packed {
      logic       granted;
      logic [5:0] granted_index;
      logic [2:0] granted_level;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] level;
      logic [1:0] group;
   } entry_word_type;

endpackage

>>> design/plrrp_if.sv
// Valid/ready channels for the request and response words of the picker.
interface plrrp_req_if;
   logic                     valid;
   logic                     ready;
   plrrp_pkg::req_word_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface plrrp_rsp_if;
   logic                     valid;
   logic                     ready;
   plrrp_pkg::rsp_word_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/priority_level_round_robin_picker.sv
// Strict-priority round-robin picker: entry table, level pointers and scan sequencer.
//
// Usage:
//   req_chan carries one request word: write an entry, pick an entry, or
//   clear all level pointers. rsp_chan returns exactly one response word per
//   request, in order; only a pick can return granted = 1.
//   A write or a clear passes through ST_RESP before its response is loaded.
//   A pick visits the levels one at a time; each level scans the table from
//   its pointer with one table read per cycle and one compare per cycle.
//   The single table read port and the one entry compare set that rate.
//   req_chan.ready is high only while no request is in progress; a new
//   request is taken while an earlier response still sits in the output
//   register, but its own response waits until that register is taken.
//   Reset clears every runnable flag and every level pointer at once, so the
//   block accepts a request in the first cycle after reset.
//   A stalled rsp_chan holds its word stable until ready is seen.
module priority_level_round_robin_picker (
   input  logic         clock,
   input  logic         reset,
   plrrp_req_if.sink    req_chan,
   plrrp_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic                           order_ff, order_in;
   logic [1:0]                     filter_ff, filter_in;
   logic [plrrp_pkg::SLOT_W-1:0]   slot_cnt_ff, slot_cnt_in;
   logic [plrrp_pkg::OFF_W-1:0]    off_ff, off_in;
   logic                           rd_valid_ff, rd_valid_in;
   plrrp_pkg::rsp_word_type        pend_ff, pend_in;
   logic                           out_valid_ff, out_valid_in;
   plrrp_pkg::rsp_word_type        out_word_ff, out_word_in;

   logic [plrrp_pkg::IDX_W-1:0]    ptr_ff [plrrp_pkg::LEVELS];
   logic                           ready_ff [plrrp_pkg::ENTRIES];
   plrrp_pkg::entry_word_type      entry_mem [plrrp_pkg::ENTRIES];

   plrrp_pkg::entry_word_type      rd_word_ff;
   logic                           rd_ready_ff;
   logic [plrrp_pkg::IDX_W-1:0]    rd_idx_ff;

   logic                           req_fire;
   logic                           wr_ok;
   logic [plrrp_pkg::IDX_W-1:0]    wr_idx;
   logic [2:0]                     wr_level;
   logic [plrrp_pkg::SLOT_W-1:0]   slot_sel;
   logic [plrrp_pkg::LV_W-1:0]     cur_lv;
   logic [plrrp_pkg::IDX_W-1:0]    cur_ptr;
   logic                           issue;
   logic [plrrp_pkg::OFF_W-1:0]    addr_sum;
   logic [plrrp_pkg::IDX_W-1:0]    rd_addr;
   logic                           hit;
   logic                           level_end;
   logic                           last_level;
   logic [plrrp_pkg::IDX_W-1:0]    next_ptr;

   // Handshake
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   // Write decode: drop indexes beyond the table, fold bad levels
   assign wr_ok  = plrrp_pkg::IDX_FITS ||
                   (req_chan.payload.entry_index < 6'(plrrp_pkg::ENTRIES));
   assign wr_idx = plrrp_pkg::IDX_W'(req_chan.payload.entry_index);
   always_comb begin
      if (req_chan.payload.priority_req < plrrp_pkg::LEVEL_MIN ||
          req_chan.payload.priority_req > plrrp_pkg::LEVEL_MAX) begin
         wr_level = plrrp_pkg::FALLBACK_LEVEL;
      end else begin
         wr_level = req_chan.payload.priority_req;
      end
   end

   // Level being visited and its pointer slot
   assign slot_sel = order_ff ? (plrrp_pkg::SLOT_W'(plrrp_pkg::LEVELS - 1) - slot_cnt_ff)
                              : slot_cnt_ff;
   assign cur_lv   = plrrp_pkg::LV_W'(slot_sel) + plrrp_pkg::LV_W'(1);
   assign cur_ptr  = ptr_ff[slot_sel];
   assign last_level = (slot_cnt_ff == plrrp_pkg::SLOT_W'(plrrp_pkg::LEVELS - 1));

   // Scan address: pointer plus offset, wrapped around the table
   assign issue    = (state_ff == ST_SCAN) && (off_ff < plrrp_pkg::OFF_W'(plrrp_pkg::ENTRIES));
   assign addr_sum = {1'b0, cur_ptr} + off_ff;
   always_comb begin
      if (addr_sum >= plrrp_pkg::OFF_W'(plrrp_pkg::ENTRIES)) begin
         rd_addr = plrrp_pkg::IDX_W'(addr_sum - plrrp_pkg::OFF_W'(plrrp_pkg::ENTRIES));
      end else begin
         rd_addr = plrrp_pkg::IDX_W'(addr_sum);
      end
   end

   // Compare the entry read last cycle against the visited level and queue
   assign hit = rd_valid_ff && rd_ready_ff &&
                (plrrp_pkg::LV_W'(rd_word_ff.level) == cur_lv) &&
                (rd_word_ff.group == filter_ff);
   assign level_end = (state_ff == ST_SCAN) && rd_valid_ff && !hit &&
                      (off_ff == plrrp_pkg::OFF_W'(plrrp_pkg::ENTRIES));
   assign next_ptr  = (rd_idx_ff == plrrp_pkg::IDX_W'(plrrp_pkg::ENTRIES - 1)) ?
                      '0 : rd_idx_ff + plrrp_pkg::IDX_W'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      filter_in    = filter_ff;
      slot_cnt_in  = slot_cnt_ff;
      off_in       = off_ff;
      rd_valid_in  = issue;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;

      // drop the output word once taken
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               order_in    = req_chan.payload.order;
               filter_in   = req_chan.payload.queue_filter;
               slot_cnt_in = '0;
               off_in      = '0;
               pend_in     = '0;
               if (req_chan.payload.action == plrrp_pkg::ACT_PICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               off_in = off_ff + plrrp_pkg::OFF_W'(1);
            end
            if (hit) begin
               pend_in.granted       = 1'b1;
               pend_in.granted_index = 6'(rd_idx_ff);
               pend_in.granted_level = 3'(cur_lv);
               rd_valid_in           = 1'b0;
               state_in              = ST_RESP;
            end else if (level_end) begin
               off_in = '0;
               if (last_level) begin
                  state_in = ST_RESP;
               end else begin
                  slot_cnt_in = slot_cnt_ff + plrrp_pkg::SLOT_W'(1);
               end
            end
         end
         ST_RESP: begin
            // load the output word when the register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_word_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      order_ff    <= order_in;
      filter_ff   <= filter_in;
      slot_cnt_ff <= slot_cnt_in;
      off_ff      <= off_in;
      pend_ff     <= pend_in;
      out_word_ff <= out_word_in;
   end

   // Runnable flags and level pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < plrrp_pkg::ENTRIES; i++) begin
            ready_ff[i] <= 1'b0;
         end
         for (int k = 0; k < plrrp_pkg::LEVELS; k++) begin
            ptr_ff[k] <= '0;
         end
      end else begin
         if (req_fire && req_chan.payload.action == plrrp_pkg::ACT_WRITE && wr_ok) begin
            ready_ff[wr_idx] <= req_chan.payload.runnable;
         end
         if (req_fire && req_chan.payload.action == plrrp_pkg::ACT_CLEAR) begin
            for (int k = 0; k < plrrp_pkg::LEVELS; k++) begin
               ptr_ff[k] <= '0;
            end
         end
         if (state_ff == ST_SCAN && hit) begin
            ptr_ff[slot_sel] <= next_ptr;
         end
      end
   end

   // Entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.payload.action == plrrp_pkg::ACT_WRITE && wr_ok) begin
         entry_mem[wr_idx] <= '{level: wr_level, group: req_chan.payload.entry_queue};
      end
      rd_word_ff  <= entry_mem[rd_addr];
      rd_ready_ff <= ready_ff[rd_addr];
      rd_idx_ff   <= rd_addr;
   end

`ifndef SYNTHESIS
   // a grant always reports a real level
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.granted) |-> (out_word_ff.granted_level != 3'd0))
      else $error("grant with level zero");

   // no grant means an all-zero word
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_word_ff.granted) |->
      (out_word_ff.granted_index == 6'd0 && out_word_ff.granted_level == 3'd0))
      else $error("non-grant word not zero");

   // a grant moves that level's pointer just past the granted entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit) |=> (ptr_ff[$past(slot_sel)] == $past(next_ptr)))
      else $error("level pointer not advanced on grant");

   // the scan offset never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (off_ff <= plrrp_pkg::OFF_W'(plrrp_pkg::ENTRIES)))
      else $error("scan offset overrun");

   // table reads are only in flight during a scan
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("read in flight outside scan");
`endif

endmodule
